// ===== rtl/wtfi_pkg.sv =====
// ----------------------------------------------------------------------------
// wtfi_pkg
// Shared widths, register indexes, defaults and pipeline structs of the
// wave-terrain frame interpolator.
// ----------------------------------------------------------------------------
package wtfi_pkg;

  localparam int TABLE_DEPTH_DEF = 16384;
  localparam int MAX_FRAMES_DEF  = 32;

  localparam int FS_W      = 15;
  localparam int FC_W      = 6;
  localparam int TL_W      = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 20;
  localparam int LADDR_W   = 14;
  localparam int FRAC_W    = 17;
  localparam int SPAN_W    = FS_W + FC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd2;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [FS_W-1:0] FRAME_SIZE_RST   = 15'd512;
  localparam logic [FC_W-1:0] FRAME_COUNT_RST  = 6'd2;
  localparam logic [TL_W-1:0] TABLE_LENGTH_RST = 15'd0;
  localparam logic [FS_W-1:0] FRAME_SIZE_MAX   = 15'd16384;

  localparam int RF_DEPTH  = 16;
  localparam int RF_PTR_W  = $clog2(RF_DEPTH);
  localparam int RF_CNT_W  = $clog2(RF_DEPTH + 1);

  typedef struct packed {
    logic                       valid;
    logic                       kind;
    logic                       oor;
    logic [TL_W-1:0]            ia;
    logic [TL_W-1:0]            ib;
    logic [FRAC_W-1:0]          frac;
    logic [LADDR_W-1:0]         waddr;
    logic                       wok;
    logic signed [SAMPLE_W-1:0] wdata;
  } table_req_t;

  typedef struct packed {
    logic                       valid;
    logic                       oor;
    logic [FRAC_W-1:0]          frac;
    logic signed [SAMPLE_W-1:0] va;
    logic signed [SAMPLE_W-1:0] vb;
  } table_rsp_t;

  typedef struct packed {
    logic                       valid;
    logic                       oor;
    logic signed [SAMPLE_W-1:0] sample;
  } result_t;

endpackage

// ===== rtl/wave_terrain_frame_interpolator.sv =====
// ----------------------------------------------------------------------------
// wave_terrain_frame_interpolator
// Takes one item per clock: kind 0 writes a table sample, kind 1 returns one
// crossfaded sample between two neighboring wavetable frames. A sample item
// is answered after passing the address pipeline, table read, blend and
// output queue; table writes and reads use the same pipeline stage, so a
// write is seen by every later item. Up to 16 sample items may be
// outstanding, and the item channel stalls while 16 of them are
// outstanding, whether still in flight or waiting in the output queue. The
// table has no reset value: entries must be written before they are read.
// ----------------------------------------------------------------------------
module wave_terrain_frame_interpolator #(
  parameter int TABLE_DEPTH = wtfi_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_FRAMES  = wtfi_pkg::MAX_FRAMES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wtfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wtfi_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 kind,
  input  logic [wtfi_pkg::LADDR_W-1:0]         load_address,
  input  logic signed [wtfi_pkg::SAMPLE_W-1:0] load_value,
  input  logic signed [wtfi_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [wtfi_pkg::COORD_W-1:0]  y_coord,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [wtfi_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 out_of_range
);
  import wtfi_pkg::*;

  table_req_t          req;
  table_rsp_t          rsp;
  result_t             res;
  logic                accept;
  logic                pop;
  logic [RF_CNT_W-1:0] used;
  logic [RF_CNT_W-1:0] fifo_count;
  logic                take;

  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign take       = accept && (kind == KIND_SAMPLE);
  assign item_stall = (used == RF_CNT_W'(RF_DEPTH));

  // outstanding sample items, in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case ({take, pop})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

  wtfi_addr_pipe #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .kind        (kind),
    .load_address(load_address),
    .load_value  (load_value),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .req         (req)
  );

  wtfi_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  wtfi_blend u_blend (
    .clk(clk),
    .rst(rst),
    .rsp(rsp),
    .res(res)
  );

  wtfi_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .pop         (pop),
    .result_valid(result_valid),
    .sample_out  (sample_out),
    .out_of_range(out_of_range),
    .count       (fifo_count)
  );

`ifndef SYNTHESIS
  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= used)
    else $error("output queue holds more items than were taken");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (used != '0))
    else $error("result produced with no outstanding sample item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && (used == '0))
    else $error("result pending after reset");
`endif

endmodule

// ===== rtl/wtfi_addr_pipe.sv =====
// ----------------------------------------------------------------------------
// wtfi_addr_pipe
// Configuration registers and the four-stage coordinate pipeline that turns
// an item into two table addresses, a crossfade fraction and a range flag.
// ----------------------------------------------------------------------------
module wtfi_addr_pipe #(
  parameter int TABLE_DEPTH = wtfi_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_FRAMES  = wtfi_pkg::MAX_FRAMES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_write,
  input  logic [wtfi_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [wtfi_pkg::CFG_W-1:0]                  cfg_data,
  input  logic                                        accept,
  input  logic                                        kind,
  input  logic [wtfi_pkg::LADDR_W-1:0]                load_address,
  input  logic signed [wtfi_pkg::SAMPLE_W-1:0]        load_value,
  input  logic signed [wtfi_pkg::COORD_W-1:0]         x_coord,
  input  logic signed [wtfi_pkg::COORD_W-1:0]         y_coord,
  output wtfi_pkg::table_req_t                        req
);
  import wtfi_pkg::*;

  logic [FS_W-1:0]   frame_size;
  logic [FC_W-1:0]   frame_count;
  logic [TL_W-1:0]   table_length;
  logic [SPAN_W-1:0] span;

  logic [FS_W-1:0] fs_val;
  logic [FC_W-1:0] fc_val;
  logic [TL_W-1:0] tl_val;

  // register writes with clamping
  always_comb begin
    fs_val = cfg_data[FS_W-1:0];
    if (fs_val == '0) fs_val = 15'd1;
    if (fs_val > FRAME_SIZE_MAX) fs_val = FRAME_SIZE_MAX;
    fc_val = cfg_data[FC_W-1:0];
    if (fc_val < 6'd2) fc_val = 6'd2;
    if (32'(fc_val) > MAX_FRAMES) fc_val = FC_W'(MAX_FRAMES);
    tl_val = cfg_data[TL_W-1:0];
    if (32'(tl_val) > TABLE_DEPTH) tl_val = TL_W'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size   <= FRAME_SIZE_RST;
      frame_count  <= FRAME_COUNT_RST;
      table_length <= TABLE_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_SIZE:   frame_size   <= fs_val;
        CFG_FRAME_COUNT:  frame_count  <= fc_val;
        CFG_TABLE_LENGTH: table_length <= tl_val;
        default: ;
      endcase
    end
  end

  // distance from first to last frame at a column
  always_ff @(posedge clk) begin
    span <= SPAN_W'(frame_count - 6'd1) * SPAN_W'(frame_size);
  end

  // stage 1: clamp coordinates
  logic                       s1_valid;
  logic                       s1_kind;
  logic [LADDR_W-1:0]         s1_waddr;
  logic                       s1_wok;
  logic signed [SAMPLE_W-1:0] s1_wdata;
  logic [18:0]                s1_x;
  logic [16:0]                s1_y;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
    s1_kind  <= kind;
    s1_waddr <= load_address;
    s1_wok   <= 32'(load_address) < TABLE_DEPTH;
    s1_wdata <= load_value;
    s1_x     <= x_coord[COORD_W-1] ? 19'd0 : x_coord[18:0];
    if (y_coord[COORD_W-1])           s1_y <= 17'd0;
    else if (y_coord > 20'sd65536)    s1_y <= 17'd65536;
    else                              s1_y <= y_coord[16:0];
  end

  // stage 2: scale x by frame size, y by frame count minus one
  logic                       s2_valid;
  logic                       s2_kind;
  logic [LADDR_W-1:0]         s2_waddr;
  logic                       s2_wok;
  logic signed [SAMPLE_W-1:0] s2_wdata;
  logic [17:0]                s2_colraw;
  logic [22:0]                s2_s;
  logic [33:0]                prod_x;

  assign prod_x = 34'(s1_x) * 34'(frame_size);

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_kind   <= s1_kind;
    s2_waddr  <= s1_waddr;
    s2_wok    <= s1_wok;
    s2_wdata  <= s1_wdata;
    s2_colraw <= prod_x[33:16];
    s2_s      <= 23'(s1_y) * 23'(frame_count - 6'd1);
  end

  // stage 3: column clamps, range test, frame pick
  logic [FS_W-1:0] col;
  logic [TL_W-1:0] col_t;
  logic            oor;
  logic [7:0]      q;
  logic [7:0]      p_raw;
  logic [7:0]      p_max;
  logic [7:0]      p_sel;
  logic [23:0]     frac_full;

  always_comb begin
    col   = (s2_colraw >= 18'(frame_size)) ? frame_size - 15'd1 : s2_colraw[FS_W-1:0];
    col_t = (col >= table_length) ? table_length - 15'd1 : col;
    oor   = (table_length == '0) ||
            ((22'(col_t) + 22'(span)) >= 22'(table_length));
    q     = 8'((24'(s2_s) + 24'd65535) >> 16);
    p_raw = (q == 8'd0) ? 8'd0 : q - 8'd1;
    p_max = 8'(frame_count) - 8'd2;
    p_sel = (p_raw > p_max) ? p_max : p_raw;
    frac_full = 24'(s2_s) - {p_sel, 16'h0000};
  end

  logic                       s3_valid;
  logic                       s3_kind;
  logic [LADDR_W-1:0]         s3_waddr;
  logic                       s3_wok;
  logic signed [SAMPLE_W-1:0] s3_wdata;
  logic [TL_W-1:0]            s3_col;
  logic [FC_W-1:0]            s3_p;
  logic [FRAC_W-1:0]          s3_frac;
  logic                       s3_oor;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_kind  <= s2_kind;
    s3_waddr <= s2_waddr;
    s3_wok   <= s2_wok;
    s3_wdata <= s2_wdata;
    s3_col   <= col_t;
    s3_p     <= FC_W'(p_sel);
    s3_frac  <= frac_full[FRAC_W-1:0];
    s3_oor   <= oor;
  end

  // stage 4: table addresses of the two neighboring frames
  logic [21:0] ia_full;

  assign ia_full = 22'(s3_col) + 22'(s3_p) * 22'(frame_size);

  always_ff @(posedge clk) begin
    if (rst) req.valid <= 1'b0;
    else     req.valid <= s3_valid;
    req.kind  <= s3_kind;
    req.oor   <= s3_oor;
    req.ia    <= ia_full[TL_W-1:0];
    req.ib    <= ia_full[TL_W-1:0] + frame_size;
    req.frac  <= s3_frac;
    req.waddr <= s3_waddr;
    req.wok   <= s3_wok;
    req.wdata <= s3_wdata;
  end

endmodule

// ===== rtl/wtfi_table.sv =====
// ----------------------------------------------------------------------------
// wtfi_table
// Sample table: one write port and two registered read ports, all used from
// the same pipeline stage so item order is kept without forwarding.
// ----------------------------------------------------------------------------
module wtfi_table #(
  parameter int TABLE_DEPTH = wtfi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wtfi_pkg::table_req_t req,
  output wtfi_pkg::table_rsp_t rsp
);
  import wtfi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic signed [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  logic we;
  logic re;

  assign we = req.valid && (req.kind == KIND_WRITE) && req.wok;
  assign re = req.valid && (req.kind == KIND_SAMPLE) && !req.oor;

  always_ff @(posedge clk) begin
    if (we) mem[AW'(req.waddr)] <= req.wdata;
    if (re) begin
      rsp.va <= mem[AW'(req.ia)];
      rsp.vb <= mem[AW'(req.ib)];
    end
    if (rst) rsp.valid <= 1'b0;
    else     rsp.valid <= req.valid && (req.kind == KIND_SAMPLE);
    rsp.oor  <= req.oor;
    rsp.frac <= req.frac;
  end

endmodule

// ===== rtl/wtfi_blend.sv =====
// ----------------------------------------------------------------------------
// wtfi_blend
// Crossfade of the two frame samples: one multiply stage, then add, round
// half away from zero and saturate; out-of-range items give zero.
// ----------------------------------------------------------------------------
module wtfi_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  wtfi_pkg::table_rsp_t rsp,
  output wtfi_pkg::result_t    res
);
  import wtfi_pkg::*;

  // va*65536 + frac*(vb-va)
  logic signed [16:0] diff;
  logic signed [34:0] prod;

  assign diff = 17'(rsp.vb) - 17'(rsp.va);
  assign prod = 35'($signed({1'b0, rsp.frac})) * 35'(diff);

  logic                       a_valid;
  logic                       a_oor;
  logic signed [SAMPLE_W-1:0] a_va;
  logic signed [34:0]         a_prod;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= rsp.valid;
    a_oor  <= rsp.oor;
    a_va   <= rsp.va;
    a_prod <= prod;
  end

  logic signed [35:0]         acc;
  logic signed [35:0]         rnd;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    acc = (36'(a_va) <<< 16) + 36'(a_prod);
    if (acc[35]) rnd = (acc + 36'sd32767) >>> 16;
    else         rnd = (acc + 36'sd32768) >>> 16;
    if (rnd > 36'sd32767)       sat = 16'sh7fff;
    else if (rnd < -36'sd32768) sat = -16'sh8000;
    else                        sat = rnd[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else     res.valid <= a_valid;
    res.oor    <= a_oor;
    res.sample <= a_oor ? '0 : sat;
  end

endmodule

// ===== rtl/wtfi_result_fifo.sv =====
// ----------------------------------------------------------------------------
// wtfi_result_fifo
// Output queue that decouples the pipeline from a stalled result channel.
// ----------------------------------------------------------------------------
module wtfi_result_fifo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wtfi_pkg::result_t                    res,
  input  logic                                 pop,
  output logic                                 result_valid,
  output logic signed [wtfi_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 out_of_range,
  output logic [wtfi_pkg::RF_CNT_W-1:0]        count
);
  import wtfi_pkg::*;

  logic signed [SAMPLE_W-1:0] q_sample [RF_DEPTH];
  logic                       q_oor    [RF_DEPTH];
  logic [RF_PTR_W-1:0]        wr_ptr;
  logic [RF_PTR_W-1:0]        rd_ptr;

  always_ff @(posedge clk) begin
    if (res.valid) begin
      q_sample[wr_ptr] <= res.sample;
      q_oor[wr_ptr]    <= res.oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)       rd_ptr <= rd_ptr + 1'b1;
      case ({res.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign result_valid = (count != '0);
  assign sample_out   = q_sample[rd_ptr];
  assign out_of_range = q_oor[rd_ptr];

endmodule
